@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the array engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked every clock, held off while reset is high.
`define IATE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked every clock, reset included.
`define IATE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/iate_pkg.sv @@
// Package: beat types, command and status codes, cell operation codes.
`default_nettype none

package iate_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned IDX_W        = 7;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CMD_W        = 4;
  localparam int unsigned STATUS_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 4'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FILL   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_READ   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // operation broadcast to every cell; only checked, accepted commands get one
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_ERASE,
    OP_INSERT,
    OP_RESIZE,
    OP_FILL,
    OP_READ,
    OP_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         new_length;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [IDX_W-1:0]         length;
    logic                     is_empty;
    logic signed [WORD_W-1:0] read_data;
  } out_beat_t;

endpackage

`default_nettype wire

@@ src/iate_cell.sv @@
// One array slot: holds an entry and shifts it to or from its neighbors.
`default_nettype none

module iate_cell #(
  parameter int unsigned POS   = 0,
  parameter int unsigned CMP_W = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  iate_pkg::cell_ctl_t      ctl,
  input  logic [CMP_W-1:0]         idx,
  input  logic [CMP_W-1:0]         len,
  input  logic [CMP_W-1:0]         nlen,
  input  logic [iate_pkg::WORD_W-1:0] lower,
  input  logic [iate_pkg::WORD_W-1:0] upper,
  input  logic [iate_pkg::WORD_W-1:0] rd_in,
  output logic [iate_pkg::WORD_W-1:0] entry,
  output logic [iate_pkg::WORD_W-1:0] rd_out
);
  import iate_pkg::*;

  localparam logic [CMP_W-1:0] POS_C  = CMP_W'(POS);
  localparam logic [CMP_W-1:0] POS_P1 = CMP_W'(POS + 1);

  logic [WORD_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      OP_APPEND: begin
        if (POS_C == len) entry_next = ctl.value;
      end
      OP_ERASE: begin
        if (POS_C >= idx && POS_P1 < len) entry_next = upper;
      end
      OP_INSERT: begin
        if (POS_C == idx) begin
          entry_next = ctl.value;
        end else if (POS_C > idx && POS_C <= len) begin
          entry_next = lower;
        end
      end
      OP_RESIZE: begin
        if (POS_C >= len && POS_C < nlen) entry_next = '0;
      end
      OP_FILL: begin
        if (POS_C < nlen) entry_next = ctl.value;
      end
      OP_WRITE: begin
        if (POS_C == idx) entry_next = ctl.value;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

  // read data rides an OR chain down the row
  assign rd_out = rd_in | ((ctl.op == OP_READ && POS_C == idx) ? entry : '0);

endmodule

`default_nettype wire

@@ src/indexed_array_table_engine_unit.sv @@
// Top level: command decode, length register, row of cells, result register.
//
// Ordered array of CAPACITY signed 32-bit words with a live length.
// Input channel in_valid/in_stall/in_data carries one command beat
// (append, remove last, clear, erase, insert, resize, fill, read, write).
// Output channel out_valid/out_stall/out_data returns exactly one beat per
// command: status, length after the command, empty flag and read data.
// The result beat is registered: it appears in the cycle after the command is
// accepted. Throughput: one command per cycle unless the receiver stalls. Every
// slot is a cell that updates in the same cycle, so erase and insert shift the
// whole tail in one step; the read path is an OR chain through the row.
// When the receiver stalls, the result beat holds in the output register and
// in_stall rises, so no further command is taken until the beat leaves.
// Reset (rst, synchronous) clears every entry to zero, the length to zero and
// drops out_valid; commands are taken as soon as reset is released.
// Rejected commands (bad index, capacity exceeded) change nothing.
`default_nettype none

module indexed_array_table_engine_unit #(
  parameter int unsigned CAPACITY = iate_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  iate_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iate_pkg::out_beat_t out_data
);
  import iate_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [LEN_W-1:0]  live_count;
  logic [LEN_W-1:0]  live_count_next;
  logic              out_valid_next;
  out_beat_t         out_data_next;
  logic              accept;
  logic [STATUS_W-1:0] status;
  cell_ctl_t         ctl;
  logic [CMP_W-1:0]  len_e;
  logic [CMP_W-1:0]  idx_e;
  logic [CMP_W-1:0]  nlen_e;
  logic [CMP_W-1:0]  len_next_e;

  logic [WORD_W-1:0] entry_w [CAPACITY];
  logic [WORD_W-1:0] rd_w    [CAPACITY+1];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign len_e  = CMP_W'(live_count);
  assign idx_e  = CMP_W'(in_data.index);
  assign nlen_e = CMP_W'(in_data.new_length);

  // command check and length update; the cells only see checked operations
  always_comb begin
    ctl.op          = OP_NONE;
    ctl.value       = in_data.value;
    status          = ST_OK;
    live_count_next = live_count;
    if (accept) begin
      case (in_data.command)
        CMD_APPEND: begin
          if (len_e >= CAP_C) begin
            status = ST_FULL;
          end else begin
            ctl.op          = OP_APPEND;
            live_count_next = live_count + LEN_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (live_count != '0) live_count_next = live_count - LEN_W'(1);
        end
        CMD_CLEAR: begin
          live_count_next = '0;
        end
        CMD_ERASE: begin
          if (idx_e >= len_e) begin
            status = ST_RANGE;
          end else begin
            ctl.op          = OP_ERASE;
            live_count_next = live_count - LEN_W'(1);
          end
        end
        CMD_INSERT: begin
          if (idx_e > len_e) begin
            status = ST_RANGE;
          end else if (len_e >= CAP_C) begin
            status = ST_FULL;
          end else begin
            ctl.op          = OP_INSERT;
            live_count_next = live_count + LEN_W'(1);
          end
        end
        CMD_RESIZE: begin
          if (nlen_e > CAP_C) begin
            status = ST_FULL;
          end else begin
            ctl.op          = OP_RESIZE;
            live_count_next = nlen_e[LEN_W-1:0];
          end
        end
        CMD_FILL: begin
          if (nlen_e > CAP_C) begin
            status = ST_FULL;
          end else begin
            ctl.op          = OP_FILL;
            live_count_next = nlen_e[LEN_W-1:0];
          end
        end
        CMD_READ: begin
          if (idx_e >= len_e) begin
            status = ST_RANGE;
          end else begin
            ctl.op = OP_READ;
          end
        end
        CMD_WRITE: begin
          if (idx_e >= len_e) begin
            status = ST_RANGE;
          end else begin
            ctl.op = OP_WRITE;
          end
        end
        default: status = ST_OK;
      endcase
    end
  end

  // row of cells; ends see zero neighbors, which no checked op ever takes
  assign rd_w[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;

    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = entry_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_mid_hi
      assign upper_w = entry_w[g+1];
    end

    iate_cell #(
      .POS   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .idx    (idx_e),
      .len    (len_e),
      .nlen   (nlen_e),
      .lower  (lower_w),
      .upper  (upper_w),
      .rd_in  (rd_w[g]),
      .entry  (entry_w[g]),
      .rd_out (rd_w[g+1])
    );
  end

  // result beat
  assign len_next_e     = CMP_W'(live_count_next);
  assign out_valid_next = accept || (out_valid && out_stall);

  always_comb begin
    out_data_next = out_data;
    if (accept) begin
      out_data_next.status    = status;
      out_data_next.length    = len_next_e[IDX_W-1:0];
      out_data_next.is_empty  = (live_count_next == '0);
      out_data_next.read_data = rd_w[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      live_count <= live_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  `IATE_ASSERT(a_len_bound, CMP_W'(live_count) <= CAP_C, "length beyond capacity")
  `IATE_ASSERT(a_len_hold, !accept |=> $stable(live_count), "length moved without a command")
  `IATE_ASSERT(a_beat_follows, accept |=> out_valid, "accepted command gave no result")
  `IATE_ASSERT(a_reject_no_data,
    (out_valid && out_data.status != ST_OK) |-> (out_data.read_data == '0),
    "rejected command returned read data")

endmodule

`default_nettype wire

@@ tb/tb_indexed_array_table_engine_unit.sv @@
// Self-checking testbench for the indexed array table engine: random traffic with a shadow model.
`timescale 1ns / 1ps

module tb_indexed_array_table_engine_unit;
  import iate_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned RAND_ITEMS = 600;
  localparam int unsigned LONG_HOLD  = 200;     // receiver hold-off to back up the block
  localparam int unsigned SETTLE     = 8;       // the result beat is registered, leave slack
  localparam int unsigned CYCLE_CAP  = 300000;

  // codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // two copies of the array: PLAN runs ahead while stimulus is built,
  // LIVE follows the beats the block actually takes
  localparam int PLAN = 0;
  localparam int LIVE = 1;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  logic signed [WORD_W-1:0] shadow_words [2][CAP];
  int unsigned              shadow_len [2];

  in_beat_t    pending_cmds[$];
  out_beat_t   expected_results[$];
  int unsigned total_cmds  = 0;
  int unsigned sent_count  = 0;
  int unsigned got_count   = 0;
  int unsigned fail_count  = 0;
  int unsigned gap_left    = 0;
  int unsigned hold_left   = 0;
  bit          long_hold_done = 1'b0;
  int unsigned cycle_count = 0;

  indexed_array_table_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow of the array: applies one command to copy s, returns the result beat.
  function automatic out_beat_t array_step(input int s, input in_beat_t c);
    out_beat_t   r;
    int unsigned idx;
    int unsigned nlen;
    int unsigned n;
    r    = '0;
    idx  = c.index;
    nlen = c.new_length;
    n    = shadow_len[s];
    r.status = ST_OK;
    case (c.command)
      CMD_APPEND: begin
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[s][n] = c.value;
          n++;
        end
      end
      CMD_REMOVE: begin
        if (n > 0) n--;
      end
      CMD_CLEAR: n = 0;
      CMD_ERASE: begin
        if (idx >= n) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = idx; i + 1 < n; i++) shadow_words[s][i] = shadow_words[s][i+1];
          n--;
        end
      end
      CMD_INSERT: begin
        // range check wins over the capacity check
        if (idx > n) begin
          r.status = ST_RANGE;
        end else if (n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = n; i > idx; i--) shadow_words[s][i] = shadow_words[s][i-1];
          shadow_words[s][idx] = c.value;
          n++;
        end
      end
      CMD_RESIZE: begin
        if (nlen > CAP) begin
          r.status = ST_FULL;
        end else begin
          // growing exposes zeroed slots; shrinking leaves stale words behind
          for (int i = n; i < nlen; i++) shadow_words[s][i] = '0;
          n = nlen;
        end
      end
      CMD_FILL: begin
        if (nlen > CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = 0; i < nlen; i++) shadow_words[s][i] = c.value;
          n = nlen;
        end
      end
      CMD_READ: begin
        if (idx >= n) r.status = ST_RANGE;
        else r.read_data = shadow_words[s][idx];
      end
      CMD_WRITE: begin
        if (idx >= n) r.status = ST_RANGE;
        else shadow_words[s][idx] = c.value;
      end
      default: ;
    endcase
    shadow_len[s] = n;
    r.length   = n[IDX_W-1:0];
    r.is_empty = (n == 0);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long; zero in calm stretches.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                           input logic signed [WORD_W-1:0] val, input int unsigned nlen);
    in_beat_t b;
    b.command    = cmd;
    b.index      = idx[IDX_W-1:0];
    b.value      = val;
    b.new_length = nlen[IDX_W-1:0];
    pending_cmds.insert(pending_cmds.size(), b);
    void'(array_step(PLAN, b));
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Random commands, mostly well formed against the planned length. Phases
  // alternate between growing and shrinking so full and empty are both reached.
  task automatic queue_random(input int unsigned count);
    int unsigned n;
    int unsigned r;
    int unsigned idx;
    int unsigned nlen;
    bit          grow;
    logic [CMD_W-1:0] cmd;
    for (int k = 0; k < count; k++) begin
      n    = shadow_len[PLAN];
      grow = ((k / 60) % 2) == 0;
      r    = $urandom_range(0, 99);
      if (r < 12) begin
        // noise: any code, any field value
        queue_cmd(CMD_W'($urandom_range(0, 15)), $urandom_range(0, 127), $urandom,
                  $urandom_range(0, 127));
      end else begin
        r = $urandom_range(0, 99);
        if (grow) begin
          if (r < 30)      cmd = CMD_APPEND;
          else if (r < 50) cmd = CMD_INSERT;
          else if (r < 62) cmd = CMD_WRITE;
          else if (r < 77) cmd = CMD_READ;
          else if (r < 85) cmd = CMD_ERASE;
          else if (r < 90) cmd = CMD_REMOVE;
          else if (r < 95) cmd = CMD_RESIZE;
          else if (r < 99) cmd = CMD_FILL;
          else             cmd = CMD_CLEAR;
        end else begin
          if (r < 20)      cmd = CMD_ERASE;
          else if (r < 40) cmd = CMD_REMOVE;
          else if (r < 55) cmd = CMD_READ;
          else if (r < 65) cmd = CMD_WRITE;
          else if (r < 75) cmd = CMD_APPEND;
          else if (r < 83) cmd = CMD_INSERT;
          else if (r < 91) cmd = CMD_RESIZE;
          else if (r < 96) cmd = CMD_FILL;
          else             cmd = CMD_CLEAR;
        end
        if (cmd == CMD_INSERT) begin
          idx = ($urandom_range(0, 9) != 0) ? $urandom_range(0, n) : $urandom_range(n + 1, CAP + 1);
        end else begin
          idx = (n != 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
                                                      : $urandom_range(n, CAP);
        end
        r = $urandom_range(0, 9);
        if (r == 0)      nlen = CAP;
        else if (r == 1) nlen = $urandom_range(CAP + 1, 127);
        else if (r < 5)  nlen = $urandom_range(0, 8);
        else             nlen = $urandom_range(0, CAP);
        queue_cmd(cmd, idx, pick_word(), nlen);
      end
    end
  endtask

  // Command side: the beat in flight is predicted at the edge it is taken.
  always @(posedge clk) begin : cmd_drive
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(), array_step(LIVE, in_data));
        sent_count++;
      end
      // payload only moves once the current beat has gone
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() != 0) begin
          in_data  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap((sent_count % 128) < 24);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each taken beat with the oldest prediction, then
  // decide the stall for the next cycle.
  always @(posedge clk) begin : result_check
    out_beat_t   want;
    int unsigned h;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          got_count++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_data.length);
            fail_count++;
          end
          if (out_data.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
            fail_count++;
          end
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, out_data.read_data);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && got_count >= 300) begin
        // long hold-off: the sender keeps offering and must be held back
        out_stall      <= 1'b1;
        hold_left      <= LONG_HOLD - 1;
        long_hold_done <= 1'b1;
      end else begin
        h = pick_gap((got_count % 128) >= 64 && (got_count % 128) < 88);
        if (h == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          hold_left <= h - 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      shadow_len[s] = 0;
      for (int i = 0; i < CAP; i++) shadow_words[s][i] = '0;
    end

    // empty array: remove is a quiet no-op, indexed access is out of range
    queue_cmd(CMD_REMOVE, 0, '0, 0);
    queue_cmd(CMD_READ,   0, '0, 0);
    queue_cmd(CMD_ERASE,  0, '0, 0);
    queue_cmd(CMD_WRITE,  0, WORD_MAX, 0);
    queue_cmd(CMD_INSERT, 1, WORD_MAX, 0);
    // build a short array with the extreme words
    queue_cmd(CMD_INSERT, 0, WORD_MIN, 0);
    queue_cmd(CMD_APPEND, 0, WORD_MAX, 0);
    queue_cmd(CMD_APPEND, 0, -1, 0);
    queue_cmd(CMD_READ,   2, '0, 0);
    queue_cmd(CMD_WRITE,  1, '0, 0);
    queue_cmd(CMD_ERASE,  0, '0, 0);
    queue_cmd(CMD_INSERT, 2, 32'sd5, 0);     // insert right at the tail
    // resize past capacity, then to capacity with zero fill
    queue_cmd(CMD_RESIZE, 0, '0, CAP + 1);
    queue_cmd(CMD_RESIZE, 0, '0, CAP);
    queue_cmd(CMD_READ,   CAP - 1, '0, 0);
    // full array: append and insert overflow; bad index reported first
    queue_cmd(CMD_APPEND, 0, WORD_MIN, 0);
    queue_cmd(CMD_INSERT, 0, WORD_MIN, 0);
    queue_cmd(CMD_INSERT, CAP + 1, WORD_MIN, 0);
    queue_cmd(CMD_FILL,   0, 32'sh5a5a_a5a5, CAP);
    // shrink then grow: exposed slots read back as zero
    queue_cmd(CMD_RESIZE, 0, '0, 3);
    queue_cmd(CMD_RESIZE, 0, '0, 10);
    queue_cmd(CMD_READ,   9, '0, 0);
    queue_cmd(CMD_FILL,   0, -1, 0);
    queue_cmd(CMD_CLEAR,  0, '0, 0);
    queue_cmd(CMD_SPARE_LO, 5, 32'sd1, 5);
    queue_cmd(CMD_SPARE_HI, 127, -1, 127);

    queue_random(RAND_ITEMS);
    total_cmds = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_cmds || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
